// File: design/wsh_pkg.sv
// shared types, constants and mixing helpers for the word stream hash block
// no dependencies
package wsh_pkg;

  localparam logic [63:0] PRIME_1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME_2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME_3 = 64'h165667B19E3779F9;

  localparam int SHIFT_A = 33;
  localparam int SHIFT_B = 29;
  localparam int SHIFT_C = 32;

  localparam int LEN_W        = 16;
  localparam int LEN_BITS_DEF = 16;
  localparam int WORDS_W      = 14;
  localparam int SHORT_MAX    = 8;
  localparam int MEDIUM_MAX   = 16;
  localparam int QUEUE_DEPTH  = 2;

  // what the back end has to do with an item
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LONG,
    OP_SMALL,
    OP_MEDIUM
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             last;
    logic             fold_p1;
    logic [LEN_W-1:0] len;
    logic [63:0]      word;
  } wsh_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LENMUL,
    BK_AV1,
    BK_AV2,
    BK_FOLD
  } back_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  function automatic logic [63:0] mix_a(input logic [63:0] v);
    return v ^ (v >> SHIFT_A);
  endfunction

  function automatic logic [63:0] mix_b(input logic [63:0] v);
    return v ^ (v >> SHIFT_B);
  endfunction

  function automatic logic [63:0] mix_c(input logic [63:0] v);
    return v ^ (v >> SHIFT_C);
  endfunction

endpackage

// File: design/wsh_front.sv
// front end: masks the length, picks the path and prepares the word of an item
// depends on wsh_pkg
module wsh_front
  import wsh_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic [63:0]      data_word,
  input  logic [LEN_W-1:0] msg_len,
  input  logic             last_word,
  output wsh_entry_t       entry
);

  logic [LEN_W-1:0] len_mask;
  logic [LEN_W-1:0] len;
  logic [63:0]      tail_mask;
  logic [2:0]       hi_shift;
  logic [63:0]      hi_word;
  logic [63:0]      seed;
  logic             is_long;
  logic             is_small;

  function automatic logic [63:0] byte_at(input logic [63:0] w, input logic [2:0] idx);
    logic [63:0] s;
    s = w >> {idx, 3'b000};
    return {56'd0, s[7:0]};
  endfunction

  always_comb begin
    for (int i = 0; i < LEN_W; i++) begin
      len_mask[i] = (i < LEN_BITS);
    end
    len = msg_len & len_mask;
    for (int b = 0; b < 8; b++) begin
      tail_mask[b*8 +: 8] = ({1'b0, 3'(b)} < {1'b0, len[2:0]}) ? 8'hFF : 8'h00;
    end
  end

  // seed of the short path
  always_comb begin
    hi_shift = 3'(len[3:0] - 4'd4);
    hi_word  = data_word >> {hi_shift, 3'b000};
    seed     = PRIME_1;
    if (len >= LEN_W'(4)) begin
      seed = PRIME_1 ^ {hi_word[31:0], data_word[31:0]};
    end else if (len != '0) begin
      seed = PRIME_1 ^ (byte_at(data_word, 3'd0) << 16)
                     ^ (byte_at(data_word, {1'b0, len[2:1]}) << 8)
                     ^ byte_at(data_word, 3'(len[2:0] - 3'd1));
    end
  end

  always_comb begin
    is_long  = len > LEN_W'(MEDIUM_MAX);
    is_small = len <= LEN_W'(SHORT_MAX);
    entry.len     = len;
    entry.last    = last_word;
    entry.fold_p1 = 1'b0;
    entry.word    = data_word;
    priority if (is_long) begin
      entry.op      = OP_LONG;
      entry.fold_p1 = last_word && (len[2:0] != 3'd0);
      if (entry.fold_p1) begin
        entry.word = data_word & tail_mask;
      end
    end else if (!last_word) begin
      entry.op = OP_HOLD;
    end else if (is_small) begin
      entry.op   = OP_SMALL;
      entry.word = seed;
    end else begin
      entry.op = OP_MEDIUM;
    end
  end

endmodule

// File: design/wsh_queue.sv
// short item queue between the front and the back end
// depends on wsh_pkg
module wsh_queue
  import wsh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  wsh_entry_t push_entry,
  output logic       pop_valid,
  output wsh_entry_t pop_entry,
  input  logic       pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  wsh_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

endmodule

// File: design/wsh_mul64.sv
// 64x64 multiplier, low half of the product, one 32x32 multiplier used in turn for the partial products
// depends on wsh_pkg
module wsh_mul64
  import wsh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] prod;

  // step 0: lo*lo, step 1: a_hi*b_lo, step 2: a_lo*b_hi (cross terms keep low halves)
  always_comb begin
    x    = (step == 2'd1) ? a_r[63:32] : a_r[31:0];
    y    = (step == 2'd2) ? b_r[63:32] : b_r[31:0];
    prod = 64'(x) * 64'(y);
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (busy) begin
      if (step == 2'd0) begin
        acc <= prod;
      end else begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("multiplier started while busy");

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("multiplier done without a run");

endmodule

// File: design/wsh_back.sv
// back end: sequencer over the shared multiplier, hash state and result register
// depends on wsh_pkg, drives one wsh_mul64
module wsh_back
  import wsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  wsh_entry_t  q_head,
  output logic        q_pop,
  output mul_req_t    mul_req,
  input  mul_rsp_t    mul_rsp,
  output logic        hash_valid,
  input  logic        hash_ready,
  output logic [63:0] hash_value
);

  localparam logic [WORDS_W-1:0] WORDS_MAX = '1;

  back_state_t        state;
  back_state_t        state_next;
  wsh_entry_t         cur;
  logic [63:0]        hbase;
  logic               final_pass;
  logic [63:0]        running_hash;
  logic [63:0]        first_word_hold;
  logic [WORDS_W-1:0] words_seen;

  logic               take;
  logic               first;
  logic [63:0]        p;
  logic [63:0]        av_end;
  logic [63:0]        len_ext;
  logic [63:0]        w0;
  logic [63:0]        w1;
  logic [127:0]       pair;
  logic [4:0]         k;
  logic [63:0]        med_r;
  logic [63:0]        med_v;

  logic               st_step;
  logic               st_clear;
  logic [63:0]        st_word;
  logic               rh_load;
  logic               hb_load;
  logic [63:0]        hb_value;
  logic               fp_load;
  logic               fp_value;
  logic               out_load;

  assign take    = q_valid && (!q_head.last || !hash_valid);
  assign first   = words_seen == '0;
  assign p       = mul_rsp.p;
  assign av_end  = mix_c(p);
  assign len_ext = 64'(q_head.len);

  // medium path: bytes 0..7 and the last eight bytes
  always_comb begin
    w0    = first ? q_head.word : first_word_hold;
    w1    = first ? 64'd0 : q_head.word;
    k     = q_head.len[4:0] - 5'd8;
    pair  = {w1, w0} >> {k[3:0], 3'b000};
    med_r = pair[63:0];
    med_v = (w0 ^ PRIME_1) + (med_r ^ PRIME_2) + len_ext;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          unique case (q_head.op)
            OP_HOLD:   state_next = BK_IDLE;
            OP_LONG:   state_next = first ? BK_LENMUL : BK_AV1;
            OP_SMALL:  state_next = BK_LENMUL;
            OP_MEDIUM: state_next = BK_AV1;
          endcase
        end
      end
      BK_LENMUL: if (mul_rsp.done) state_next = BK_AV1;
      BK_AV1:    if (mul_rsp.done) state_next = BK_AV2;
      BK_AV2:    if (mul_rsp.done) state_next = final_pass ? BK_IDLE : BK_FOLD;
      BK_FOLD:   if (mul_rsp.done) state_next = cur.last ? BK_AV1 : BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mul_req  = '0;
    st_step  = 1'b0;
    st_clear = 1'b0;
    st_word  = cur.word;
    rh_load  = 1'b0;
    hb_load  = 1'b0;
    hb_value = running_hash;
    fp_load  = 1'b0;
    fp_value = 1'b0;
    out_load = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_HOLD: begin
              st_step = 1'b1;
              st_word = q_head.word;
            end
            OP_LONG: begin
              mul_req.start = 1'b1;
              if (first) begin
                mul_req.a = len_ext;
                mul_req.b = PRIME_1;
              end else begin
                hb_load   = 1'b1;
                fp_load   = 1'b1;
                mul_req.a = mix_a(q_head.word);
                mul_req.b = PRIME_2;
              end
            end
            OP_SMALL: begin
              mul_req.start = 1'b1;
              mul_req.a     = len_ext;
              mul_req.b     = PRIME_1;
            end
            OP_MEDIUM: begin
              mul_req.start = 1'b1;
              mul_req.a     = mix_a(med_v);
              mul_req.b     = PRIME_2;
              fp_load       = 1'b1;
              fp_value      = 1'b1;
            end
          endcase
        end
      end
      BK_LENMUL: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.b     = PRIME_2;
          fp_load       = 1'b1;
          if (cur.op == OP_SMALL) begin
            mul_req.a = mix_a(cur.word ^ p);
            fp_value  = 1'b1;
          end else begin
            hb_load   = 1'b1;
            hb_value  = p;
            mul_req.a = mix_a(cur.word);
          end
        end
      end
      BK_AV1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mix_b(p);
          mul_req.b     = PRIME_3;
        end
      end
      BK_AV2: begin
        if (mul_rsp.done) begin
          if (final_pass) begin
            out_load = 1'b1;
            st_clear = 1'b1;
          end else begin
            mul_req.start = 1'b1;
            mul_req.a     = hbase ^ av_end;
            mul_req.b     = cur.fold_p1 ? PRIME_1 : PRIME_2;
          end
        end
      end
      BK_FOLD: begin
        if (mul_rsp.done) begin
          if (cur.last) begin
            mul_req.start = 1'b1;
            mul_req.a     = mix_a(p);
            mul_req.b     = PRIME_2;
            fp_load       = 1'b1;
            fp_value      = 1'b1;
          end else begin
            rh_load = 1'b1;
            st_step = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (hb_load) begin
      hbase <= hb_value;
    end
    if (out_load) begin
      hash_value <= av_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BK_IDLE;
      final_pass      <= 1'b0;
      hash_valid      <= 1'b0;
      running_hash    <= '0;
      first_word_hold <= '0;
      words_seen      <= '0;
    end else begin
      state <= state_next;
      if (fp_load) begin
        final_pass <= fp_value;
      end
      if (out_load) begin
        hash_valid <= 1'b1;
      end else if (hash_ready) begin
        hash_valid <= 1'b0;
      end
      if (rh_load) begin
        running_hash <= p;
      end
      if (st_step) begin
        if (first) begin
          first_word_hold <= st_word;
        end
        if (words_seen != WORDS_MAX) begin
          words_seen <= words_seen + 1'b1;
        end
      end
      if (st_clear) begin
        running_hash    <= '0;
        first_word_hold <= '0;
        words_seen      <= '0;
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == BK_IDLE)
    else $error("item taken while busy");

  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> (state == BK_IDLE) || mul_rsp.done)
    else $error("multiplier started mid run");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !hash_valid)
    else $error("result overwrites a pending one");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> words_seen == '0 && running_hash == '0)
    else $error("message state not cleared after result");

endmodule

// File: design/word_stream_hash64_unit.sv
// top level of the streaming 64-bit word hash
// depends on wsh_pkg, wsh_front, wsh_queue, wsh_mul64, wsh_back
//
// channel   handshake               payload
// word      word_valid/word_ready   data_word[63:0], msg_len[15:0], last_word
// hash      hash_valid/hash_ready   hash_value[63:0]
//
// every multiply goes through one 64-bit multiplier built from a single
// 32x32 unit, used in turn for the partial products
// the first word of a long message and a short last word add a length*prime multiply
// rst clears control and hash state at once, no clearing pass
// a 2-entry queue takes items while the back end works; a last item waits
// in the queue while an earlier hash still sits untaken in the result register
module word_stream_hash64_unit
  import wsh_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             word_valid,
  output logic             word_ready,
  input  logic [63:0]      data_word,
  input  logic [LEN_W-1:0] msg_len,
  input  logic             last_word,
  output logic             hash_valid,
  input  logic             hash_ready,
  output logic [63:0]      hash_value
);

  // classified item on its way into the queue
  wsh_entry_t front_entry;
  // head of the queue seen by the back end
  wsh_entry_t head_entry;
  logic       head_valid;
  logic       head_pop;
  // shared multiplier
  mul_req_t   mul_req;
  mul_rsp_t   mul_rsp;

  // length masking, path choice, tail masking and short-path seed
  wsh_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .data_word (data_word),
    .msg_len   (msg_len),
    .last_word (last_word),
    .entry     (front_entry)
  );

  // decouples input acceptance from the multiply sequence
  wsh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (word_valid),
    .push_ready (word_ready),
    .push_entry (front_entry),
    .pop_valid  (head_valid),
    .pop_entry  (head_entry),
    .pop        (head_pop)
  );

  // low 64 bits of a 64x64 product
  wsh_mul64 u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // avalanche, fold and result sequencing plus the per-message state
  wsh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (head_valid),
    .q_head     (head_entry),
    .q_pop      (head_pop),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_value (hash_value)
  );

endmodule

// File: tb/wsh_hash_checker.sv
`timescale 1ns / 1ps
// result checker for word_stream_hash64_unit: follows both channels, predicts each hash
// depends on wsh_pkg for the field widths and mixing primes
module wsh_hash_checker
  import wsh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             word_valid,
  input  logic             word_ready,
  input  logic [63:0]      data_word,
  input  logic [LEN_W-1:0] msg_len,
  input  logic             last_word,
  input  logic             hash_valid,
  input  logic             hash_ready,
  input  logic [63:0]      hash_value,
  output int               outstanding,
  output int               mismatches
);

  logic [63:0]        running_hash;
  logic [63:0]        first_word_hold;
  logic [WORDS_W-1:0] words_seen;
  logic [63:0]        expected_hashes[$];
  int                 fails = 0;

  assign mismatches = fails;

  function automatic logic [63:0] avalanche(input logic [63:0] v);
    logic [63:0] h;
    h = v ^ (v >> SHIFT_A);
    h = h * PRIME_2;
    h = h ^ (h >> SHIFT_B);
    h = h * PRIME_3;
    return h ^ (h >> SHIFT_C);
  endfunction

  // takes one accepted item, returns 1 when it finishes a message
  function automatic bit absorb_word(input logic [63:0] w, input logic [LEN_W-1:0] len,
                                     input logic last, output logic [63:0] digest);
    logic [63:0] h, seed, w0, w1, r, mask;
    int k;
    digest = '0;
    h = '0;
    if (len > MEDIUM_MAX) begin
      h = (words_seen == 0) ? 64'(len) * PRIME_1 : running_hash;
      if (!last || len[2:0] == 3'd0) begin
        h = (h ^ avalanche(w)) * PRIME_2;
      end else begin
        // tail word keeps only its valid bytes
        mask = (64'd1 << (len[2:0] * 8)) - 64'd1;
        h = (h ^ avalanche(w & mask)) * PRIME_1;
      end
      if (!last) running_hash = h;
    end
    if (!last) begin
      if (words_seen == 0) first_word_hold = w;
      if (words_seen != '1) words_seen++;
      return 1'b0;
    end
    if (len > MEDIUM_MAX) begin
      digest = avalanche(h);
    end else if (len <= SHORT_MAX) begin
      // only the last word counts on the short path
      seed = PRIME_1;
      if (len >= 4)
        seed ^= {w[(len - 4) * 8 +: 32], w[31:0]};
      else if (len > 0)
        seed ^= {40'd0, w[7:0], w[(len >> 1) * 8 +: 8], w[(len - 1) * 8 +: 8]};
      digest = avalanche(seed ^ (64'(len) * PRIME_1));
    end else begin
      // medium message from the held first word and the last word; a single-word one reads its upper half as zero
      if (words_seen == 0) begin
        w0 = w;
        w1 = '0;
      end else begin
        w0 = first_word_hold;
        w1 = w;
      end
      k = int'(len) - 8;
      r = (k >= 8) ? w1 : (w0 >> (k * 8)) | (w1 << (64 - k * 8));
      digest = avalanche((w0 ^ PRIME_1) + (r ^ PRIME_2) + 64'(len));
    end
    running_hash = '0;
    first_word_hold = '0;
    words_seen = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [63:0] predicted;
    if (rst) begin
      running_hash = '0;
      first_word_hold = '0;
      words_seen = '0;
      expected_hashes.delete();
    end else begin
      // results first, so a hash never meets an expectation made at the same edge
      if (hash_valid && hash_ready) begin
        if (expected_hashes.size() == 0) begin
          if (fails < 10) $display("unexpected hash %h", hash_value);
          fails++;
        end else begin
          predicted = expected_hashes.pop_front();
          if (hash_value !== predicted) begin
            if (fails < 10)
              $display("hash mismatch: expected %h, got %h", predicted, hash_value);
            fails++;
          end
        end
      end
      if (word_valid && word_ready) begin
        if (absorb_word(data_word, msg_len, last_word, predicted))
          expected_hashes.push_back(predicted);
      end
    end
    outstanding <= expected_hashes.size();
  end

endmodule

// File: tb/tb_word_stream_hash64_unit.sv
`timescale 1ns / 1ps
// testbench top for word_stream_hash64_unit: drives messages and result back-pressure
// depends on wsh_pkg, word_stream_hash64_unit and wsh_hash_checker
module tb_word_stream_hash64_unit
  import wsh_pkg::*;
();

  localparam int RANDOM_WORDS  = 750;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int LONG_HOLD     = 500;
  localparam int SETTLE_CYCLES = 40;

  logic             clk;
  logic             rst;
  logic             word_valid;
  logic             word_ready;
  logic [63:0]      data_word;
  logic [LEN_W-1:0] msg_len;
  logic             last_word;
  logic             hash_valid;
  logic             hash_ready;
  logic [63:0]      hash_value;

  int outstanding;
  int mismatches;
  int cycle_count = 0;
  int words_sent = 0;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  bit hold_request = 1'b0;

  word_stream_hash64_unit dut (
    .clk       (clk),
    .rst       (rst),
    .word_valid(word_valid),
    .word_ready(word_ready),
    .data_word (data_word),
    .msg_len   (msg_len),
    .last_word (last_word),
    .hash_valid(hash_valid),
    .hash_ready(hash_ready),
    .hash_value(hash_value)
  );

  wsh_hash_checker hash_check (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .data_word  (data_word),
    .msg_len    (msg_len),
    .last_word  (last_word),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_value (hash_value),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long; zero in steady stretches
  function automatic int pick_gap(input bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic [63:0] w, input logic [LEN_W-1:0] len,
                           input logic last);
    int gap;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_valid <= 1'b1;
    data_word  <= w;
    msg_len    <= len;
    last_word  <= last;
    do @(posedge clk); while (!word_ready);
    words_sent++;
  endtask

  // one message with random content; now and then a word before the last carries a stray length
  task automatic send_message(input logic [LEN_W-1:0] len, input int words);
    logic [63:0]      w;
    logic [LEN_W-1:0] word_len;
    for (int i = 0; i < words; i++) begin
      case ($urandom_range(0, 15))
        0:       w = '0;
        1:       w = '1;
        default: w = {$urandom, $urandom};
      endcase
      word_len = len;
      if (i != words - 1 && $urandom_range(0, 19) == 0)
        word_len = LEN_W'($urandom_range(0, 65535));
      send_item(w, word_len, i == words - 1);
    end
  endtask

  // mostly well-formed messages on all three paths, some with a wrong word count
  task automatic send_random_message();
    logic [LEN_W-1:0] len;
    int               words;
    case ($urandom_range(0, 9))
      0, 1, 2:    len = LEN_W'($urandom_range(0, 8));
      3, 4:       len = LEN_W'($urandom_range(9, 16));
      5, 6, 7, 8: len = LEN_W'($urandom_range(17, 64));
      default:    len = LEN_W'($urandom_range(65, 65535));
    endcase
    // huge lengths keep a short word count so the run stays quick
    words = (len + 7) / 8;
    if (words < 1) words = 1;
    if (words > 8) words = 8;
    if ($urandom_range(0, 7) == 0) words = $urandom_range(1, 4);
    send_message(len, words);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request <= 1'b0;
        hash_ready   <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) receiver_steady = !receiver_steady;
      gap = pick_gap(receiver_steady);
      if (gap > 0) begin
        hash_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hash_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    int  base;
    bit  drained;
    rst        <= 1'b1;
    word_valid <= 1'b0;
    data_word  <= '0;
    msg_len    <= '0;
    last_word  <= 1'b0;
    hash_ready <= 1'b0;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty message, then first/middle/last byte mixing
    send_item('1, 16'd0, 1'b1);
    send_item(64'h0123456789ABCDEF, 16'd1, 1'b1);
    send_item(64'hFEDCBA9876543210, 16'd2, 1'b1);
    send_item({$urandom, $urandom}, 16'd3, 1'b1);
    // first and last four bytes, overlapping and not
    send_item('1, 16'd4, 1'b1);
    send_item({$urandom, $urandom}, 16'd8, 1'b1);
    // short message on a later word: the earlier word is dropped
    send_item('1, 16'd5, 1'b0);
    send_item('0, 16'd5, 1'b1);
    // medium message in one word, upper bytes read as zero
    send_item('1, 16'd9, 1'b1);
    // medium from the held first word and the last word
    send_item('0, 16'd16, 1'b0);
    send_item('1, 16'd16, 1'b1);
    send_item('1, 16'd12, 1'b0);
    send_item({$urandom, $urandom}, 16'd12, 1'b1);
    // long path with a one-byte tail, then a full last word
    send_item({$urandom, $urandom}, 16'd17, 1'b0);
    send_item('1, 16'd17, 1'b0);
    send_item('1, 16'd17, 1'b1);
    send_item({$urandom, $urandom}, 16'd24, 1'b0);
    send_item({$urandom, $urandom}, 16'd24, 1'b0);
    send_item('1, 16'd24, 1'b1);
    // largest length arriving as a lone last word
    send_item('1, 16'hFFFF, 1'b1);
    // path changes between the words of one message
    send_item({$urandom, $urandom}, 16'd40, 1'b0);
    send_item({$urandom, $urandom}, 16'd10, 1'b1);

    // receiver holds off while short messages pile up behind it
    hold_request <= 1'b1;
    sender_steady = 1'b1;
    repeat (20) send_message(LEN_W'($urandom_range(0, 8)), 1);
    sender_steady = 1'b0;

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
      // halfway through, let every hash drain before going on
      if (!drained && words_sent - base >= RANDOM_WORDS / 2) begin
        drained = 1'b1;
        word_valid <= 1'b0;
        // wait for the clock so the checker's count includes the item just taken
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      send_random_message();
    end
    word_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
design/wsh_pkg.sv
design/wsh_front.sv
design/wsh_queue.sv
design/wsh_mul64.sv
design/wsh_back.sv
design/word_stream_hash64_unit.sv
tb/wsh_hash_checker.sv
tb/tb_word_stream_hash64_unit.sv
